// File: design/mgg_pkg.sv
// mgg_pkg: sizes, register indexes, codes and the sequencer program of the
// masked grid gradient block. Depends on nothing; every design file imports it.
`default_nettype none

package mgg_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int X_W        = $clog2(MAX_WIDTH);
  localparam int Y_W        = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = X_W + Y_W;
  localparam int GRID_CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int SIZE_W     = 7;
  localparam int VAL_W      = 32;
  localparam int INV_W      = 32;
  localparam int HALF_W     = INV_W / 2;
  localparam int MAG_W      = VAL_W + 1;
  localparam int PROD_W     = MAG_W + HALF_W;
  localparam int ACC_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int PC_W       = 4;

  localparam logic [SIZE_W-1:0] MAX_W_SZ = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] MAX_H_SZ = SIZE_W'(MAX_HEIGHT);

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_XWRAP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_YWRAP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INVY   = 3'd5;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // read address select
  localparam logic [2:0] RD_NONE = 3'd0;
  localparam logic [2:0] RD_CTR  = 3'd1;
  localparam logic [2:0] RD_XLO  = 3'd2;
  localparam logic [2:0] RD_XHI  = 3'd3;
  localparam logic [2:0] RD_YLO  = 3'd4;
  localparam logic [2:0] RD_YHI  = 3'd5;

  // read data capture
  localparam logic [1:0] CAP_NONE = 2'd0;
  localparam logic [1:0] CAP_CTR  = 2'd1;
  localparam logic [1:0] CAP_LO   = 2'd2;
  localparam logic [1:0] CAP_HI   = 2'd3;

  // multiplier pass
  localparam logic [1:0] MUL_NONE = 2'd0;
  localparam logic [1:0] MUL_LO   = 2'd1;
  localparam logic [1:0] MUL_HI   = 2'd2;

  // finish an axis
  localparam logic [1:0] FIN_NONE = 2'd0;
  localparam logic [1:0] FIN_X    = 2'd1;
  localparam logic [1:0] FIN_Y    = 2'd2;
  localparam logic [1:0] FIN_ZERO = 2'd3;

  // sequencing
  localparam logic [1:0] JMP_SEQ  = 2'd0;
  localparam logic [1:0] JMP_SKIP = 2'd1;
  localparam logic [1:0] JMP_END  = 2'd2;

  localparam logic AX_X = 1'b0;
  localparam logic AX_Y = 1'b1;

  localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] PC_FIRST = 4'd1;
  localparam logic [PC_W-1:0] PC_ZERO  = 4'd15;

  typedef struct packed {
    logic [2:0]      rd;
    logic [1:0]      cap;
    logic            dif;
    logic [1:0]      mul;
    logic            axis;
    logic [1:0]      fin;
    logic            emit;
    logic [1:0]      jmp;
    logic [PC_W-1:0] target;
  } ctl_word_t;

  function automatic ctl_word_t ctl_word(input logic [2:0] rd, input logic [1:0] cap,
                                         input logic dif, input logic [1:0] mul,
                                         input logic axis, input logic [1:0] fin,
                                         input logic emit, input logic [1:0] jmp,
                                         input logic [PC_W-1:0] target);
    ctl_word_t w;
    w.rd     = rd;
    w.cap    = cap;
    w.dif    = dif;
    w.mul    = mul;
    w.axis   = axis;
    w.fin    = fin;
    w.emit   = emit;
    w.jmp    = jmp;
    w.target = target;
    return w;
  endfunction

  function automatic ctl_word_t ucode(input logic [PC_W-1:0] pc);
    ctl_word_t w;
    unique case (pc)
      4'd0:  w = ctl_word(RD_NONE, CAP_NONE, 1'b0, MUL_NONE, AX_X, FIN_NONE, 1'b0, JMP_END,  PC_IDLE);
      4'd1:  w = ctl_word(RD_CTR,  CAP_NONE, 1'b0, MUL_NONE, AX_X, FIN_NONE, 1'b0, JMP_SEQ,  PC_IDLE);
      4'd2:  w = ctl_word(RD_XLO,  CAP_CTR,  1'b0, MUL_NONE, AX_X, FIN_NONE, 1'b0, JMP_SKIP, PC_ZERO);
      4'd3:  w = ctl_word(RD_XHI,  CAP_LO,   1'b0, MUL_NONE, AX_X, FIN_NONE, 1'b0, JMP_SEQ,  PC_IDLE);
      4'd4:  w = ctl_word(RD_NONE, CAP_HI,   1'b0, MUL_NONE, AX_X, FIN_NONE, 1'b0, JMP_SEQ,  PC_IDLE);
      4'd5:  w = ctl_word(RD_NONE, CAP_NONE, 1'b1, MUL_NONE, AX_X, FIN_NONE, 1'b0, JMP_SEQ,  PC_IDLE);
      4'd6:  w = ctl_word(RD_NONE, CAP_NONE, 1'b0, MUL_LO,   AX_X, FIN_NONE, 1'b0, JMP_SEQ,  PC_IDLE);
      4'd7:  w = ctl_word(RD_NONE, CAP_NONE, 1'b0, MUL_HI,   AX_X, FIN_NONE, 1'b0, JMP_SEQ,  PC_IDLE);
      4'd8:  w = ctl_word(RD_YLO,  CAP_NONE, 1'b0, MUL_NONE, AX_X, FIN_X,    1'b0, JMP_SEQ,  PC_IDLE);
      4'd9:  w = ctl_word(RD_YHI,  CAP_LO,   1'b0, MUL_NONE, AX_Y, FIN_NONE, 1'b0, JMP_SEQ,  PC_IDLE);
      4'd10: w = ctl_word(RD_NONE, CAP_HI,   1'b0, MUL_NONE, AX_Y, FIN_NONE, 1'b0, JMP_SEQ,  PC_IDLE);
      4'd11: w = ctl_word(RD_NONE, CAP_NONE, 1'b1, MUL_NONE, AX_Y, FIN_NONE, 1'b0, JMP_SEQ,  PC_IDLE);
      4'd12: w = ctl_word(RD_NONE, CAP_NONE, 1'b0, MUL_LO,   AX_Y, FIN_NONE, 1'b0, JMP_SEQ,  PC_IDLE);
      4'd13: w = ctl_word(RD_NONE, CAP_NONE, 1'b0, MUL_HI,   AX_Y, FIN_NONE, 1'b0, JMP_SEQ,  PC_IDLE);
      4'd14: w = ctl_word(RD_NONE, CAP_NONE, 1'b0, MUL_NONE, AX_Y, FIN_Y,    1'b1, JMP_END,  PC_IDLE);
      4'd15: w = ctl_word(RD_NONE, CAP_NONE, 1'b0, MUL_NONE, AX_X, FIN_ZERO, 1'b1, JMP_END,  PC_IDLE);
      default: w = ctl_word(RD_NONE, CAP_NONE, 1'b0, MUL_NONE, AX_X, FIN_NONE, 1'b0, JMP_END,
                            PC_IDLE);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: design/masked_grid_gradient.sv
// masked_grid_gradient: top level; grid memory, configuration registers,
// microcoded sequencer and gradient datapath. Depends on mgg_pkg.
//
// Usage: a transaction is accepted at a rising edge with start high and busy low.
// A load (in_operation = 0) writes the value and active flag of one cell in that
// same cycle; busy stays low, so loads can follow back to back, one per cycle.
// A query (in_operation = 1) runs a 14-step program from a control ROM: five
// reads of the single-port grid memory (centre and four neighbours), a
// subtract, two passes of a 33x16 multiplier per axis and a round/saturate step.
// The result appears on out_grad_x, out_grad_y and out_saturated for exactly
// one cycle with out_valid high, registered at the last step of the program, a
// zero step if the cell is outside the grid in use or its centre is inactive.
// busy is high from the cycle after acceptance until the result cycle, so a new
// query can be accepted at the edge that ends the out_valid cycle; the memory
// reads and the shared multiplier serve one query at a time. The receiver
// cannot stall; the strobe is not held. Configuration: cfg_we writes register
// cfg_addr at once; the user must write it only while the block is idle, and
// the block does not enforce this. Reset (rst_n low, synchronous) restores the
// register defaults and idles the sequencer; grid is undefined until loaded.
`default_nettype none

module masked_grid_gradient
  import mgg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_operation,
  input  wire logic [X_W-1:0]        in_cell_x,
  input  wire logic [Y_W-1:0]        in_cell_y,
  input  wire logic signed [VAL_W-1:0] in_value,
  input  wire logic                  in_active,
  output logic                       out_valid,
  output logic signed [VAL_W-1:0]    out_grad_x,
  output logic signed [VAL_W-1:0]    out_grad_y,
  output logic                       out_saturated,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [INV_W-1:0]      cfg_wdata
);

  logic [SIZE_W-1:0] width_r, height_r;
  logic              xwrap_r, ywrap_r;
  logic [INV_W-1:0]  invx_r, invy_r;

  logic [PC_W-1:0] pc_r, pc_nxt;
  ctl_word_t       cw;

  logic [X_W-1:0] pos_x_r;
  logic [Y_W-1:0] pos_y_r;
  logic           in_range_r;

  logic [VAL_W:0]   grid_mem [GRID_CELLS];
  logic [VAL_W:0]   rdata_r;
  logic [ADDR_W-1:0] raddr;

  logic signed [VAL_W-1:0] ctr_r, lo_r, hi_r, sample;
  logic [MAG_W-1:0]  mag_r;
  logic              neg_r;
  logic [ACC_W-1:0]  acc_r;
  logic [PROD_W-1:0] prod;
  logic              sat_r;

  logic [SIZE_W-1:0] nx, ny;
  logic [X_W-1:0]    nxm1, xlo, xhi;
  logic [Y_W-1:0]    nym1, ylo, yhi;
  logic              edge_x, edge_y, cur_edge, cur_flat;
  logic [INV_W-1:0]  cur_inv;
  logic              accept, accept_query, skip;

  logic signed [MAG_W-1:0] hi_ext, lo_ext;
  logic [ACC_W-1:0]        rnd;
  logic [ACC_W-1:0]        rsh;
  logic [VAL_W-1:0]        fin_val;
  logic                    fin_sat;

  assign busy         = (pc_r != PC_IDLE);
  assign accept       = start && !busy;
  assign accept_query = accept && (in_operation == OP_QUERY);
  assign cw           = ucode(pc_r);

  always_comb begin
    if (width_r == '0) nx = SIZE_W'(1);
    else if (width_r > MAX_W_SZ) nx = MAX_W_SZ;
    else nx = width_r;
    if (height_r == '0) ny = SIZE_W'(1);
    else if (height_r > MAX_H_SZ) ny = MAX_H_SZ;
    else ny = height_r;
  end

  assign nxm1 = X_W'(nx - SIZE_W'(1));
  assign nym1 = Y_W'(ny - SIZE_W'(1));

  always_comb begin
    xlo = (pos_x_r == '0) ? (xwrap_r ? nxm1 : '0) : pos_x_r - X_W'(1);
    xhi = (pos_x_r == nxm1) ? (xwrap_r ? '0 : nxm1) : pos_x_r + X_W'(1);
    ylo = (pos_y_r == '0) ? (ywrap_r ? nym1 : '0) : pos_y_r - Y_W'(1);
    yhi = (pos_y_r == nym1) ? (ywrap_r ? '0 : nym1) : pos_y_r + Y_W'(1);
  end

  assign edge_x   = !xwrap_r && ((pos_x_r == '0) || (pos_x_r == nxm1));
  assign edge_y   = !ywrap_r && ((pos_y_r == '0) || (pos_y_r == nym1));
  assign cur_edge = (cw.axis == AX_Y) ? edge_y : edge_x;
  assign cur_flat = (cw.axis == AX_Y) ? (ny == SIZE_W'(1)) : (nx == SIZE_W'(1));
  assign cur_inv  = (cw.axis == AX_Y) ? invy_r : invx_r;

  always_comb begin
    unique case (cw.rd)
      RD_XLO:  raddr = {pos_y_r, xlo};
      RD_XHI:  raddr = {pos_y_r, xhi};
      RD_YLO:  raddr = {ylo, pos_x_r};
      RD_YHI:  raddr = {yhi, pos_x_r};
      default: raddr = {pos_y_r, pos_x_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && (in_operation == OP_LOAD)) begin
      grid_mem[{in_cell_y, in_cell_x}] <= {in_active, in_value};
    end
    rdata_r <= grid_mem[raddr];
  end

  assign skip   = !in_range_r || !rdata_r[VAL_W];
  assign sample = rdata_r[VAL_W] ? $signed(rdata_r[VAL_W-1:0]) : ctr_r;
  assign hi_ext = MAG_W'(hi_r);
  assign lo_ext = MAG_W'(lo_r);
  assign prod   = mag_r * ((cw.mul == MUL_HI) ? cur_inv[INV_W-1:HALF_W] : cur_inv[HALF_W-1:0]);
  assign rnd    = cur_edge ? (ACC_W'(1) << 15) : (ACC_W'(1) << 16);
  assign rsh    = cur_edge ? (acc_r >> 16) : (acc_r >> 17);

  always_comb begin
    fin_sat = 1'b0;
    if (cur_flat) begin
      fin_val = '0;
    end else if (neg_r) begin
      if (rsh > ACC_W'(33'h0_8000_0000)) begin
        fin_sat = 1'b1;
        fin_val = 32'h8000_0000;
      end else begin
        fin_val = VAL_W'(0) - rsh[VAL_W-1:0];
      end
    end else if (rsh > ACC_W'(32'h7FFF_FFFF)) begin
      fin_sat = 1'b1;
      fin_val = 32'h7FFF_FFFF;
    end else begin
      fin_val = rsh[VAL_W-1:0];
    end
  end

  always_comb begin
    pc_nxt = pc_r;
    if (pc_r == PC_IDLE) begin
      if (accept_query) pc_nxt = PC_FIRST;
    end else begin
      unique case (cw.jmp)
        JMP_END:  pc_nxt = PC_IDLE;
        JMP_SKIP: pc_nxt = skip ? cw.target : pc_r + PC_W'(1);
        default:  pc_nxt = pc_r + PC_W'(1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= PC_IDLE;
      out_valid <= 1'b0;
      width_r   <= MAX_W_SZ;
      height_r  <= MAX_H_SZ;
      xwrap_r   <= 1'b0;
      ywrap_r   <= 1'b0;
      invx_r    <= INV_W'(65536);
      invy_r    <= INV_W'(65536);
    end else begin
      pc_r      <= pc_nxt;
      out_valid <= (pc_r != PC_IDLE) && cw.emit;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_WIDTH:  width_r  <= cfg_wdata[SIZE_W-1:0];
          REG_HEIGHT: height_r <= cfg_wdata[SIZE_W-1:0];
          REG_XWRAP:  xwrap_r  <= cfg_wdata[0];
          REG_YWRAP:  ywrap_r  <= cfg_wdata[0];
          REG_INVX:   invx_r   <= cfg_wdata;
          REG_INVY:   invy_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_query) begin
      pos_x_r    <= in_cell_x;
      pos_y_r    <= in_cell_y;
      in_range_r <= (SIZE_W'(in_cell_x) < nx) && (SIZE_W'(in_cell_y) < ny);
      sat_r      <= 1'b0;
    end
    unique case (cw.cap)
      CAP_CTR: ctr_r <= $signed(rdata_r[VAL_W-1:0]);
      CAP_LO:  lo_r  <= sample;
      CAP_HI:  hi_r  <= sample;
      default: ;
    endcase
    if (cw.dif) begin
      neg_r <= (hi_r < lo_r);
      mag_r <= (hi_r < lo_r) ? MAG_W'(lo_ext - hi_ext) : MAG_W'(hi_ext - lo_ext);
    end
    unique case (cw.mul)
      MUL_LO:  acc_r <= ACC_W'(prod) + rnd;
      MUL_HI:  acc_r <= acc_r + ACC_W'({prod, {HALF_W{1'b0}}});
      default: ;
    endcase
    unique case (cw.fin)
      FIN_X: begin
        out_grad_x <= fin_val;
        sat_r      <= sat_r | fin_sat;
      end
      FIN_Y: begin
        out_grad_y    <= fin_val;
        out_saturated <= sat_r | fin_sat;
      end
      FIN_ZERO: begin
        out_grad_x    <= '0;
        out_grad_y    <= '0;
        out_saturated <= 1'b0;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
